@@ design/ctd_pkg.sv @@
// shared types, register codes and helpers for the confirmed threshold event detector
package ctd_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CONFIRM_W  = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned SECONDS_W  = 48;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned SER_STEPS  = 32;
    localparam int unsigned SER_CNT_W  = $clog2(SER_STEPS);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BOOM_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOM_CONFIRM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOM_MODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAOS_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAOS_CONFIRM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAOS_MODE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD    = 3'd6;

    // mode bits
    localparam int unsigned MODE_SLOPE_BIT = 0;
    localparam int unsigned MODE_ABOVE_BIT = 1;

    // input op codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0]   threshold;
        logic [CONFIRM_W-1:0]       confirm;
        logic [MODE_W-1:0]          mode;
    } t_chan_cfg;

    typedef struct packed {
        logic                       confirmed;
        logic [DATA_W-1:0]          first_frame;
        logic signed [DATA_W-1:0]   first_value;
        logic signed [DATA_W-1:0]   first_slope;
    } t_chan_rec;

    typedef struct packed {
        logic                       start;
        logic                       is_div;
        logic [DATA_W:0]            init_hi;
        logic [DATA_W-1:0]          init_lo;
        logic [DATA_W-1:0]          operand;
    } t_ser_req;

    typedef struct packed {
        logic                       done;
        logic [DATA_W-1:0]          hi;
        logic [DATA_W-1:0]          lo;
    } t_ser_rsp;

    // magnitude of a two's complement word, -2^31 maps to 2^31
    function automatic logic [DATA_W-1:0] abs_mag(input logic [DATA_W-1:0] v);
        abs_mag = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ design/ctd_serial_unit.sv @@
// shared shift-add multiplier and restoring divider, one bit per cycle
module ctd_serial_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctd_pkg::t_ser_req i_req,
    output ctd_pkg::t_ser_rsp o_rsp
);
    import ctd_pkg::*;

    logic [DATA_W:0]     r_hi;
    logic [DATA_W-1:0]   r_lo;
    logic [DATA_W-1:0]   r_operand;
    logic                r_is_div;
    logic                r_run;
    logic                r_done;
    logic [SER_CNT_W-1:0] r_cnt;

    logic [DATA_W:0]     add_a;
    logic [DATA_W:0]     add_b;
    logic [DATA_W+1:0]   sum;
    logic [DATA_W:0]     n_hi;
    logic [DATA_W-1:0]   n_lo;
    logic                div_ge;

    // one adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        if (r_is_div) begin
            add_a = {r_hi[DATA_W-1:0], r_lo[DATA_W-1]};
            add_b = ~{1'b0, r_operand};
        end else begin
            add_a = r_hi;
            add_b = r_lo[0] ? {1'b0, r_operand} : '0;
        end
        sum    = {1'b0, add_a} + {1'b0, add_b} + {{(DATA_W+1){1'b0}}, r_is_div};
        div_ge = sum[DATA_W+1];
        if (r_is_div) begin
            n_hi = div_ge ? sum[DATA_W:0] : add_a;
            n_lo = {r_lo[DATA_W-2:0], div_ge};
        end else begin
            n_hi = {1'b0, sum[DATA_W:1]};
            n_lo = {sum[0], r_lo[DATA_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_run     <= 1'b1;
            r_done    <= 1'b0;
            r_cnt     <= '0;
            r_is_div  <= i_req.is_div;
            r_hi      <= i_req.init_hi;
            r_lo      <= i_req.init_lo;
            r_operand <= i_req.operand;
        end else if (r_run) begin
            r_hi  <= n_hi;
            r_lo  <= n_lo;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == SER_CNT_W'(SER_STEPS - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi[DATA_W-1:0];
    assign o_rsp.lo   = r_lo;

endmodule

@@ design/ctd_chan.sv @@
// one detection channel: crossing test, run counter and first-crossing record
module ctd_chan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ctd_pkg::t_chan_cfg                i_cfg,
    input  logic                              i_eval,
    input  logic                              i_clear,
    input  logic [ctd_pkg::DATA_W-1:0]        i_idx,
    input  logic signed [ctd_pkg::DATA_W-1:0] i_value,
    input  logic signed [ctd_pkg::DATA_W-1:0] i_slope,
    output logic                              o_hit,
    output ctd_pkg::t_chan_rec                o_rec
);
    import ctd_pkg::*;

    logic [CONFIRM_W-1:0]     r_run;
    logic                     r_confirmed;
    logic [DATA_W-1:0]        r_first_frame;
    logic signed [DATA_W-1:0] r_first_value;
    logic signed [DATA_W-1:0] r_first_slope;

    logic signed [DATA_W-1:0] x;
    logic                     crosses;
    logic [CONFIRM_W-1:0]     run_inc;

    always_comb begin
        x       = i_cfg.mode[MODE_SLOPE_BIT] ? i_slope : i_value;
        crosses = i_cfg.mode[MODE_ABOVE_BIT] ? (x > i_cfg.threshold) : (x < i_cfg.threshold);
        run_inc = (&r_run) ? r_run : r_run + 1'b1;
        o_hit   = i_eval && crosses && (run_inc >= i_cfg.confirm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_run         <= '0;
            r_confirmed   <= 1'b0;
            r_first_frame <= '0;
            r_first_value <= '0;
            r_first_slope <= '0;
        end else if (i_eval) begin
            if (!crosses) begin
                r_run <= '0;
            end else begin
                r_run <= run_inc;
                if (r_run == '0) begin
                    r_first_frame <= i_idx;
                    r_first_value <= i_value;
                    r_first_slope <= i_slope;
                end
                if (o_hit) begin
                    r_confirmed <= 1'b1;
                end
            end
        end
    end

    assign o_rec.confirmed   = r_confirmed;
    assign o_rec.first_frame = r_first_frame;
    assign o_rec.first_value = r_first_value;
    assign o_rec.first_slope = r_first_slope;

endmodule

@@ design/confirmed_threshold_event_detector_unit.sv @@
// top level of the two-channel confirmed threshold event detector
//
// Each frame transfer is tested against the boom and chaos thresholds in the
// cycle it is taken; a frame that confirms no channel, and a clear op, leave
// o_stall low, so the next transfer can follow at once. A frame that confirms
// a channel produces an event that is worked out on one shared serial unit:
// a 32-step shift-add multiply for cross_seconds, then, when the threshold is
// nonzero and the ratio does not saturate, a 32-step restoring divide for
// sharpness. The event is offered once this work is done; it then waits as
// long as i_stall holds it. A frame that confirms both channels starts the
// second event only once the first has been transferred. The shared unit
// works one bit per cycle. Input stall stays high until every event of the
// frame has been transferred; the two events of one frame come out boom
// first, and o_last marks the final one.
module confirmed_threshold_event_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [ctd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ctd_pkg::DATA_W-1:0]          i_cfg_data,
    // frame input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic signed [ctd_pkg::DATA_W-1:0]   i_boom_value,
    input  logic signed [ctd_pkg::DATA_W-1:0]   i_boom_slope,
    input  logic signed [ctd_pkg::DATA_W-1:0]   i_chaos_value,
    input  logic signed [ctd_pkg::DATA_W-1:0]   i_chaos_slope,
    // event output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_event_id,
    output logic [ctd_pkg::DATA_W-1:0]          o_cross_frame,
    output logic [ctd_pkg::SECONDS_W-1:0]       o_cross_seconds,
    output logic signed [ctd_pkg::DATA_W-1:0]   o_cross_value,
    output logic signed [ctd_pkg::DATA_W-1:0]   o_cross_slope,
    output logic [ctd_pkg::DATA_W-1:0]          o_sharpness,
    output logic                                o_sharpness_valid,
    output logic                                o_last
);
    import ctd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_DIV
    } t_state;

    // result holding flag, high while an event waits on the output
    typedef enum logic {
        OUT_NONE,
        OUT_HOLD
    } t_out;

    // configuration registers
    t_chan_cfg         r_cfg_boom;
    t_chan_cfg         r_cfg_chaos;
    logic [DATA_W-1:0] r_frame_period;

    // sequencer state and registered results
    t_state              r_state, n_state;
    t_out                r_out, n_out;
    logic [1:0]          r_pend, n_pend;
    logic                r_ch, n_ch;
    logic [SECONDS_W-1:0] r_secs, n_secs;
    logic [DATA_W-1:0]   r_sharp, n_sharp;
    logic                r_sharp_valid, n_sharp_valid;
    logic [DATA_W-1:0]   r_frame_count;

    logic       in_xfer;
    logic       out_xfer;
    logic       frame_xfer;
    logic       clear_xfer;
    logic       eval_boom;
    logic       eval_chaos;
    logic       hit_boom;
    logic       hit_chaos;
    t_chan_rec  rec_boom;
    t_chan_rec  rec_chaos;
    t_chan_rec  rec_sel;
    t_chan_cfg  cfg_sel;
    logic       start_ch;
    t_ser_req   ser_req;
    t_ser_rsp   ser_rsp;
    logic [DATA_W-1:0] mag_slope;
    logic [DATA_W-1:0] mag_thr;
    logic [1:0]  pend_left;

    // handshakes
    assign o_stall    = (r_state != S_IDLE) || (r_out != OUT_NONE);
    assign o_valid    = (r_out == OUT_HOLD);
    assign in_xfer    = i_valid && !o_stall;
    assign out_xfer   = o_valid && !i_stall;
    assign frame_xfer = in_xfer && (i_op == OP_FRAME);
    assign clear_xfer = in_xfer && (i_op == OP_CLEAR);

    // chaos only runs once boom is confirmed, including in this same frame
    assign eval_boom  = frame_xfer && !rec_boom.confirmed;
    assign eval_chaos = frame_xfer && (rec_boom.confirmed || hit_boom) && !rec_chaos.confirmed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_boom.threshold  <= '0;
            r_cfg_boom.confirm    <= CONFIRM_W'(1);
            r_cfg_boom.mode       <= MODE_W'(2);
            r_cfg_chaos.threshold <= '0;
            r_cfg_chaos.confirm   <= CONFIRM_W'(1);
            r_cfg_chaos.mode      <= MODE_W'(2);
            r_frame_period        <= DATA_W'(1092);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BOOM_THRESHOLD:  r_cfg_boom.threshold  <= i_cfg_data;
                CFG_BOOM_CONFIRM:    r_cfg_boom.confirm    <= i_cfg_data[CONFIRM_W-1:0];
                CFG_BOOM_MODE:       r_cfg_boom.mode       <= i_cfg_data[MODE_W-1:0];
                CFG_CHAOS_THRESHOLD: r_cfg_chaos.threshold <= i_cfg_data;
                CFG_CHAOS_CONFIRM:   r_cfg_chaos.confirm   <= i_cfg_data[CONFIRM_W-1:0];
                CFG_CHAOS_MODE:      r_cfg_chaos.mode      <= i_cfg_data[MODE_W-1:0];
                CFG_FRAME_PERIOD:    r_frame_period        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // frame numbering, kept across clear ops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
        end else if (frame_xfer) begin
            r_frame_count <= r_frame_count + 1'b1;
        end
    end

    ctd_chan u_boom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg_boom),
        .i_eval  (eval_boom),
        .i_clear (clear_xfer),
        .i_idx   (r_frame_count),
        .i_value (i_boom_value),
        .i_slope (i_boom_slope),
        .o_hit   (hit_boom),
        .o_rec   (rec_boom)
    );

    ctd_chan u_chaos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg_chaos),
        .i_eval  (eval_chaos),
        .i_clear (clear_xfer),
        .i_idx   (r_frame_count),
        .i_value (i_chaos_value),
        .i_slope (i_chaos_slope),
        .o_hit   (hit_chaos),
        .o_rec   (rec_chaos)
    );

    ctd_serial_unit u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ser_req),
        .o_rsp   (ser_rsp)
    );

    // the channel being worked on: chosen from pending bits at start
    assign start_ch  = !r_pend[0];
    assign rec_sel   = (r_state == S_START ? start_ch : r_ch) ? rec_chaos : rec_boom;
    assign cfg_sel   = r_ch ? r_cfg_chaos : r_cfg_boom;
    assign mag_slope = abs_mag(rec_sel.first_slope);
    assign mag_thr   = abs_mag(cfg_sel.threshold);
    assign pend_left = r_pend & ~(2'b01 << r_ch);

    always_comb begin
        n_state       = r_state;
        n_out         = r_out;
        n_pend        = r_pend;
        n_ch          = r_ch;
        n_secs        = r_secs;
        n_sharp       = r_sharp;
        n_sharp_valid = r_sharp_valid;

        ser_req.start   = 1'b0;
        ser_req.is_div  = 1'b0;
        ser_req.init_hi = '0;
        ser_req.init_lo = r_frame_period;
        ser_req.operand = rec_sel.first_frame;

        case (r_state)
            S_IDLE: begin
                if (r_out == OUT_HOLD) begin
                    if (out_xfer) begin
                        n_out  = OUT_NONE;
                        n_pend = pend_left;
                        if (pend_left != '0) begin
                            n_state = S_START;
                        end
                    end
                end else if (frame_xfer && (hit_boom || hit_chaos)) begin
                    n_pend  = {hit_chaos, hit_boom};
                    n_state = S_START;
                end
            end
            S_START: begin
                // seconds = first_frame * frame_period
                n_ch          = start_ch;
                ser_req.start = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                if (ser_rsp.done) begin
                    // product above 48 bits saturates
                    if (ser_rsp.hi[DATA_W-1:SECONDS_W-DATA_W] != '0) begin
                        n_secs = '1;
                    end else begin
                        n_secs = {ser_rsp.hi[SECONDS_W-DATA_W-1:0], ser_rsp.lo};
                    end
                    if (mag_thr == '0) begin
                        n_sharp       = '1;
                        n_sharp_valid = 1'b0;
                        n_out         = OUT_HOLD;
                        n_state       = S_IDLE;
                    end else if ({{(DATA_W-FRAC_W){1'b0}}, mag_slope[DATA_W-1:FRAC_W]}
                                 >= mag_thr) begin
                        // quotient would not fit in 32 bits
                        n_sharp       = '1;
                        n_sharp_valid = 1'b1;
                        n_out         = OUT_HOLD;
                        n_state       = S_IDLE;
                    end else begin
                        // (|slope| << 16) / |threshold|, high part already below divisor
                        ser_req.start   = 1'b1;
                        ser_req.is_div  = 1'b1;
                        ser_req.init_hi = {{(DATA_W-FRAC_W+1){1'b0}},
                                           mag_slope[DATA_W-1:FRAC_W]};
                        ser_req.init_lo = {mag_slope[FRAC_W-1:0], {FRAC_W{1'b0}}};
                        ser_req.operand = mag_thr;
                        n_sharp_valid   = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (ser_rsp.done) begin
                    n_sharp = ser_rsp.lo;
                    n_out   = OUT_HOLD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out   <= OUT_NONE;
            r_pend  <= '0;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out   <= n_out;
            r_pend  <= n_pend;
            r_ch    <= n_ch;
        end
        r_secs        <= n_secs;
        r_sharp       <= n_sharp;
        r_sharp_valid <= n_sharp_valid;
    end

    // event payload; channel records hold still once confirmed
    assign o_event_id        = r_ch;
    assign o_cross_frame     = rec_sel.first_frame;
    assign o_cross_seconds   = r_secs;
    assign o_cross_value     = rec_sel.first_value;
    assign o_cross_slope     = rec_sel.first_slope;
    assign o_sharpness       = r_sharp;
    assign o_sharpness_valid = r_sharp_valid;
    assign o_last            = (pend_left == '0);

endmodule

@@ tb/confirmed_threshold_event_detector_unit_tb.sv @@
// self-checking regression for the two-channel confirmed threshold event detector
`timescale 1ns / 1ps

module confirmed_threshold_event_detector_unit_tb;
    import ctd_pkg::*;

    // channel codes as carried in event_id
    localparam int CH_BOOM  = 0;
    localparam int CH_CHAOS = 1;

    // mode codes: bit0 picks the slope, bit1 tests above
    localparam logic [MODE_W-1:0] MODE_VALUE_BELOW = 2'b00;
    localparam logic [MODE_W-1:0] MODE_SLOPE_BELOW = 2'b01;
    localparam logic [MODE_W-1:0] MODE_VALUE_ABOVE = 2'b10;
    localparam logic [MODE_W-1:0] MODE_SLOPE_ABOVE = 2'b11;

    localparam logic [63:0] SECONDS_MAX  = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint      S32_MIN      = 64'shFFFF_FFFF_8000_0000;
    localparam longint      S32_MAX      = 64'sh0000_0000_7FFF_FFFF;
    // allowance for a frame's worst case: two events, each with the divide
    localparam int          EVENT_LATENCY = 160;

    typedef struct packed {
        logic                   event_id;
        logic [DATA_W-1:0]      cross_frame;
        logic [SECONDS_W-1:0]   cross_seconds;
        logic [DATA_W-1:0]      cross_value;
        logic [DATA_W-1:0]      cross_slope;
        logic [DATA_W-1:0]      sharpness;
        logic                   sharpness_valid;
        logic                   last;
    } t_detector_event;

    // dut ports
    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DATA_W-1:0]      i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic                   i_op = OP_FRAME;
    logic signed [DATA_W-1:0] i_boom_value = '0;
    logic signed [DATA_W-1:0] i_boom_slope = '0;
    logic signed [DATA_W-1:0] i_chaos_value = '0;
    logic signed [DATA_W-1:0] i_chaos_slope = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic                   o_event_id;
    logic [DATA_W-1:0]      o_cross_frame;
    logic [SECONDS_W-1:0]   o_cross_seconds;
    logic signed [DATA_W-1:0] o_cross_value;
    logic signed [DATA_W-1:0] o_cross_slope;
    logic [DATA_W-1:0]      o_sharpness;
    logic                   o_sharpness_valid;
    logic                   o_last;

    // shadow copy of the registers, at their reset values
    logic [DATA_W-1:0]      thr_reg [2]     = '{32'd0, 32'd0};
    logic [CONFIRM_W-1:0]   confirm_reg [2] = '{8'd1, 8'd1};
    logic [MODE_W-1:0]      mode_reg [2]    = '{MODE_VALUE_ABOVE, MODE_VALUE_ABOVE};
    logic [DATA_W-1:0]      period_reg      = 32'd1092;

    // shadow detection state
    logic [DATA_W-1:0]      frame_ctr = '0;
    logic [CONFIRM_W-1:0]   run_len [2]     = '{8'd0, 8'd0};
    logic [DATA_W-1:0]      first_frame [2] = '{32'd0, 32'd0};
    logic [DATA_W-1:0]      first_value [2] = '{32'd0, 32'd0};
    logic [DATA_W-1:0]      first_slope [2] = '{32'd0, 32'd0};
    logic                   confirmed [2]   = '{1'b0, 1'b0};

    t_detector_event        predicted_detections [$];
    t_detector_event        oldest_detection;
    int                     fail_count = 0;

    // idling knobs: percent of cycles, and a forced receiver hold-off
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_off_request = 0;
    int                     hold_left = 0;

    confirmed_threshold_event_detector_unit i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic logic [63:0] magnitude(input logic [DATA_W-1:0] v);
        longint s;
        s = longint'(signed'(v));
        return (s < 0) ? -s : s;
    endfunction

    // one channel for one frame; returns 1 and fills ev when it confirms
    function automatic bit eval_channel(input int ch, input logic [DATA_W-1:0] idx,
                                        input logic [DATA_W-1:0] val,
                                        input logic [DATA_W-1:0] slope,
                                        output t_detector_event ev);
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] t;
        bit crosses;
        logic [63:0] secs;
        logic [63:0] tmag;
        logic [63:0] ratio;
        ev = '0;
        x = mode_reg[ch][MODE_SLOPE_BIT] ? slope : val;
        t = thr_reg[ch];
        // strict compare both ways, equal is never a crossing
        crosses = mode_reg[ch][MODE_ABOVE_BIT] ? (x > t) : (x < t);
        if (!crosses) begin
            run_len[ch] = '0;
            return 1'b0;
        end
        if (run_len[ch] == 0) begin
            first_frame[ch] = idx;
            first_value[ch] = val;
            first_slope[ch] = slope;
        end
        if (run_len[ch] != 8'hFF) run_len[ch] = run_len[ch] + 1'b1;
        // a confirm count of zero confirms on the first crossing
        if (run_len[ch] < confirm_reg[ch]) return 1'b0;

        confirmed[ch] = 1'b1;
        secs = 64'(first_frame[ch]) * 64'(period_reg);
        if (secs > SECONDS_MAX) secs = SECONDS_MAX;
        tmag = magnitude(thr_reg[ch]);
        ev.event_id      = ch[0];
        ev.cross_frame   = first_frame[ch];
        ev.cross_seconds = secs[SECONDS_W-1:0];
        ev.cross_value   = first_value[ch];
        ev.cross_slope   = first_slope[ch];
        if (tmag != 0) begin
            ratio = (magnitude(first_slope[ch]) << FRAC_W) / tmag;
            if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
            ev.sharpness       = ratio[DATA_W-1:0];
            ev.sharpness_valid = 1'b1;
        end else begin
            // zero threshold: ratio pinned high and flagged invalid
            ev.sharpness       = '1;
            ev.sharpness_valid = 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_detections(input logic op, input logic [DATA_W-1:0] bv,
                                      input logic [DATA_W-1:0] bs,
                                      input logic [DATA_W-1:0] cv,
                                      input logic [DATA_W-1:0] cs);
        t_detector_event ev;
        t_detector_event found [$];
        logic [DATA_W-1:0] idx;
        if (op == OP_CLEAR) begin
            // clear keeps the frame count and produces nothing
            for (int ch = 0; ch < 2; ch++) begin
                run_len[ch]     = '0;
                first_frame[ch] = '0;
                first_value[ch] = '0;
                first_slope[ch] = '0;
                confirmed[ch]   = 1'b0;
            end
            return;
        end
        idx = frame_ctr;
        frame_ctr = frame_ctr + 1'b1;
        if (!confirmed[CH_BOOM]) begin
            if (eval_channel(CH_BOOM, idx, bv, bs, ev)) found.insert(found.size(), ev);
        end
        // chaos only runs once boom is latched, possibly in this same frame
        if (confirmed[CH_BOOM] && !confirmed[CH_CHAOS]) begin
            if (eval_channel(CH_CHAOS, idx, cv, cs, ev)) found.insert(found.size(), ev);
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[k]) predicted_detections.insert(predicted_detections.size(), found[k]);
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------

    // one frame or clear transfer; valid stays high afterwards so that
    // back-to-back items need no drop in between
    task automatic send_item(input logic op, input logic [DATA_W-1:0] bv,
                             input logic [DATA_W-1:0] bs,
                             input logic [DATA_W-1:0] cv,
                             input logic [DATA_W-1:0] cs);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_boom_value  <= bv;
        i_boom_slope  <= bs;
        i_chaos_value <= cv;
        i_chaos_slope <= cs;
        // inputs are stable at the falling edge, so stall seen there is
        // what the next rising edge acts on
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        predict_detections(op, bv, bs, cv, cs);
    endtask

    // drop valid, let every predicted event come out, then allow for any
    // work still in flight
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_detections.size() != 0) @(posedge i_clk);
        repeat (EVENT_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_BOOM_THRESHOLD:  thr_reg[CH_BOOM]      = data;
            CFG_BOOM_CONFIRM:    confirm_reg[CH_BOOM]  = data[CONFIRM_W-1:0];
            CFG_BOOM_MODE:       mode_reg[CH_BOOM]     = data[MODE_W-1:0];
            CFG_CHAOS_THRESHOLD: thr_reg[CH_CHAOS]     = data;
            CFG_CHAOS_CONFIRM:   confirm_reg[CH_CHAOS] = data[CONFIRM_W-1:0];
            CFG_CHAOS_MODE:      mode_reg[CH_CHAOS]    = data[MODE_W-1:0];
            CFG_FRAME_PERIOD:    period_reg            = data;
            default: ;
        endcase
    endtask

    // writes all seven registers once the block has gone quiet
    task automatic configure(input logic [DATA_W-1:0] bt, input logic [CONFIRM_W-1:0] bc,
                             input logic [MODE_W-1:0] bm, input logic [DATA_W-1:0] ct,
                             input logic [CONFIRM_W-1:0] cc, input logic [MODE_W-1:0] cm,
                             input logic [DATA_W-1:0] period);
        wait_for_idle();
        write_reg(CFG_BOOM_THRESHOLD, bt);
        write_reg(CFG_BOOM_CONFIRM, 32'(bc));
        write_reg(CFG_BOOM_MODE, 32'(bm));
        write_reg(CFG_CHAOS_THRESHOLD, ct);
        write_reg(CFG_CHAOS_CONFIRM, 32'(cc));
        write_reg(CFG_CHAOS_MODE, 32'(cm));
        write_reg(CFG_FRAME_PERIOD, period);
    endtask

    // ---------------------------------------------------------------
    // receiver and checking
    // ---------------------------------------------------------------

    // random stall, or a forced hold-off counted down here
    always @(posedge i_clk) begin
        if (hold_off_request != 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic check_field(input string field, input logic [63:0] exp,
                               input logic [63:0] act);
        if (act !== exp) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp, act);
            fail_count++;
        end
    endtask

    // outputs are settled at the falling edge; a transfer happens at the
    // next rising edge when valid is up and stall is down
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_detections.size() == 0) begin
                $error("event transfer with nothing predicted: id %0d frame %0d",
                       o_event_id, o_cross_frame);
                fail_count++;
            end else begin
                oldest_detection = predicted_detections.pop_front();
                check_field("event_id", 64'(oldest_detection.event_id), 64'(o_event_id));
                check_field("cross_frame", 64'(oldest_detection.cross_frame),
                            64'(o_cross_frame));
                check_field("cross_seconds", 64'(oldest_detection.cross_seconds),
                            64'(o_cross_seconds));
                check_field("cross_value", 64'(oldest_detection.cross_value),
                            64'(o_cross_value[DATA_W-1:0]));
                check_field("cross_slope", 64'(oldest_detection.cross_slope),
                            64'(o_cross_slope[DATA_W-1:0]));
                check_field("sharpness", 64'(oldest_detection.sharpness), 64'(o_sharpness));
                check_field("sharpness_valid", 64'(oldest_detection.sharpness_valid),
                            64'(o_sharpness_valid));
                check_field("last", 64'(oldest_detection.last), 64'(o_last));
            end
        end
    end

    // ---------------------------------------------------------------
    // random value helpers
    // ---------------------------------------------------------------

    function automatic logic [DATA_W-1:0] random_field();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_threshold();
        logic [DATA_W-1:0] r;
        case ($urandom_range(6))
            0: r = '0;
            1: r = 32'h8000_0000;
            2: r = 32'h7FFF_FFFF;
            3, 4: begin
                // small magnitudes so sharpness lands in range
                r = $urandom_range(32'h0003_0000);
                if ($urandom_range(1)) r = -r;
            end
            default: r = $urandom;
        endcase
        return r;
    endfunction

    // a metric that crosses thr (hit) or fails to, hugging both ends of the
    // allowed span; falls back to anything when no such value exists
    function automatic logic [DATA_W-1:0] metric_sample(input logic [DATA_W-1:0] thr,
                                                        input logic above, input bit hit);
        longint t;
        longint lo;
        longint hi;
        longint v;
        longint span;
        logic [63:0] r;
        t = longint'(signed'(thr));
        if (above) begin
            lo = hit ? t + 1 : S32_MIN;
            hi = hit ? S32_MAX : t;
        end else begin
            lo = hit ? S32_MIN : t;
            hi = hit ? t - 1 : S32_MAX;
        end
        if (lo > hi) return $urandom;
        span = hi - lo + 1;
        case ($urandom_range(3))
            0: v = lo;
            1: v = hi;
            default: begin
                r = {$urandom, $urandom};
                v = lo + longint'(r % span);
            end
        endcase
        return v[DATA_W-1:0];
    endfunction

    // mostly frames shaped to build runs on the active channel, a clear
    // now and then and more often once both are latched, some pure noise
    task automatic send_random_frame(input int hit_pct);
        logic [DATA_W-1:0] fields [4];
        logic [DATA_W-1:0] cmp;
        int ch;
        if ((confirmed[CH_BOOM] && confirmed[CH_CHAOS] && $urandom_range(1) == 1)
                || $urandom_range(99) < 3) begin
            send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            return;
        end
        for (ch = 0; ch < 2; ch++) begin
            cmp = metric_sample(thr_reg[ch], mode_reg[ch][MODE_ABOVE_BIT],
                                $urandom_range(99) < hit_pct);
            fields[2*ch]   = mode_reg[ch][MODE_SLOPE_BIT] ? random_field() : cmp;
            fields[2*ch+1] = mode_reg[ch][MODE_SLOPE_BIT] ? cmp : random_field();
        end
        if ($urandom_range(99) < 12) begin
            foreach (fields[k]) fields[k] = $urandom;
        end
        send_item(OP_FRAME, fields[0], fields[1], fields[2], fields[3]);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset values: zero thresholds, value above, confirm one; both channels
    // fire on the first frame with the ratio flagged invalid
    task automatic test_power_on_defaults();
        send_item(OP_FRAME, 32'd1, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF);
        // both latched now, this one must stay silent
        send_item(OP_FRAME, 32'd5, 32'd5, 32'd5, 32'd5);
        send_item(OP_CLEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    endtask

    // extreme thresholds, immediate confirm, saturated ratio, max period
    task automatic test_field_extremes();
        configure(32'h8000_0000, 8'd0, MODE_SLOPE_ABOVE,
                  32'h0000_0001, 8'd0, MODE_SLOPE_BELOW, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        // slope equal to the minimum threshold is not above it
        send_item(OP_FRAME, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_FRAME, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_FRAME, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF);
    endtask

    // broken and completed runs, equal-to-threshold frames, latching
    task automatic test_confirmation_runs();
        configure(32'd100, 8'd3, MODE_VALUE_BELOW,
                  32'hFFFF_FFFB, 8'd2, MODE_VALUE_ABOVE, 32'h0001_0000);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_FRAME, 32'd99, 32'd7, 32'd0, 32'd0);
        send_item(OP_FRAME, 32'd100, 32'd0, 32'd0, 32'd0);
        send_item(OP_FRAME, 32'd50, 32'hFFFF_FFFD, 32'd0, 32'd0);
        send_item(OP_FRAME, 32'd40, 32'd9, 32'd0, 32'd0);
        // boom confirms here, chaos starts its run in the same frame
        send_item(OP_FRAME, 32'd30, 32'd1, 32'hFFFF_FFFC, 32'd11);
        send_item(OP_FRAME, 32'd0, 32'd0, 32'hFFFF_FFFB, 32'd12);
        send_item(OP_FRAME, 32'd0, 32'd0, 32'hFFFF_FFFD, 32'hFFFF_0000);
        send_item(OP_FRAME, 32'd0, 32'd0, 32'hFFFF_FFFE, 32'd14);
        send_item(OP_FRAME, 32'd0, 32'd0, 32'd100, 32'd15);
    endtask

    // receiver holds off while frames keep coming, so the block backs up
    task automatic test_input_backpressure();
        configure(32'h0000_0400, 8'd0, MODE_VALUE_ABOVE,
                  32'hFFFF_FC00, 8'd0, MODE_VALUE_BELOW, 32'd1092);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_request = 300;
        repeat (6) begin
            send_item(OP_FRAME, 32'h0001_0000, $urandom, 32'hFFFF_0000, $urandom);
            send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_random_regression();
        int hit_pct;
        int count;
        for (int phase = 0; phase < 16; phase++) begin
            wait_for_idle();
            // idle profiles rotate: none, sender, receiver, both
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (phase == 3) begin
                // one phase pushes the run counter all the way to its ceiling
                configure(random_threshold(), 8'd255, 2'($urandom_range(3)),
                          random_threshold(), 8'($urandom_range(4)),
                          2'($urandom_range(3)), $urandom);
                hit_pct = 100;
                count = 300;
            end else begin
                configure(random_threshold(),
                          ($urandom_range(5) == 0) ? 8'($urandom_range(8, 20))
                                                   : 8'($urandom_range(4)),
                          2'($urandom_range(3)),
                          random_threshold(), 8'($urandom_range(4)),
                          2'($urandom_range(3)),
                          ($urandom_range(3) == 0) ? random_field() : $urandom);
                case ($urandom_range(2))
                    0:       hit_pct = 60;
                    1:       hit_pct = 85;
                    default: hit_pct = 97;
                endcase
                count = 100;
            end
            repeat (count) send_random_frame(hit_pct);
        end
    endtask

    // max period with the frame count past a thousand fills the upper
    // bits of the 48-bit seconds field
    task automatic test_max_period_seconds();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(32'h0, 8'd0, MODE_VALUE_ABOVE,
                  32'h7FFF_FFFF, 8'd0, MODE_VALUE_BELOW, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_FRAME, 32'd1, $urandom, 32'h7FFF_FFFE, $urandom);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_FRAME, 32'd1, $urandom, 32'h7FFF_FFFE, $urandom);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_on_defaults();
        test_field_extremes();
        test_confirmation_runs();
        test_input_backpressure();
        test_random_regression();
        test_max_period_seconds();
        wait_for_idle();
        if (fail_count == 0) begin
            $display("confirmed_threshold_event_detector_unit regression: pass");
        end else begin
            $display("confirmed_threshold_event_detector_unit regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("confirmed_threshold_event_detector_unit regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ctd_pkg.sv
design/ctd_serial_unit.sv
design/ctd_chan.sv
design/confirmed_threshold_event_detector_unit.sv
tb/confirmed_threshold_event_detector_unit_tb.sv
